// ----- rtl/arp_pkg.sv -----
package arp_pkg;

   localparam int ADDR_WIDTH   = 12;
   localparam int STATUS_WIDTH = 2;
   localparam int NUM_SIZES    = 36;
   localparam int P_WIDTH      = 7;
   localparam int Q_WIDTH      = 4;
   localparam int OFS_WIDTH    = 11;   // largest phase offset is 1200
   localparam int SUM_WIDTH    = 18;   // p*i + offset + 3 stays below 2^18
   localparam int RECIP_SHIFT  = SUM_WIDTH;
   localparam int RECIP_WIDTH  = 13;   // floor(2^18 / n), n >= 56
   localparam int PROD_WIDTH   = SUM_WIDTH + RECIP_WIDTH;
   localparam int QUOT_WIDTH   = PROD_WIDTH - RECIP_SHIFT;
   localparam int REM_WIDTH    = ADDR_WIDTH + 1;   // estimate lands below 2n

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_SIZE  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BAD_INDEX = 2'd2;

   localparam logic [ADDR_WIDTH-1:0] FRAME_SIZE_RESET = 12'd56;

   typedef logic [ADDR_WIDTH-1:0]   addr_type;
   typedef logic [STATUS_WIDTH-1:0] status_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0]  n;
      logic [P_WIDTH-1:0]     p;
      logic [Q_WIDTH-1:0]     q0;
      logic [Q_WIDTH-1:0]     q1;
      logic [Q_WIDTH-1:0]     q2;
      logic [Q_WIDTH-1:0]     q3;
      logic [RECIP_WIDTH-1:0] recip;
   } arp_entry_type;

   // size, period, q0..q3, floor(2^18 / size)
   localparam arp_entry_type ARP_TABLE [NUM_SIZES] = '{
      '{12'd152,  7'd17,  4'd9,  4'd5,  4'd14, 4'd1, 13'd1724},
      '{12'd56,   7'd9,   4'd2,  4'd2,  4'd8,  4'd0, 13'd4681},
      '{12'd236,  7'd23,  4'd10, 4'd2,  4'd11, 4'd1, 13'd1110},
      '{12'd340,  7'd23,  4'd6,  4'd13, 4'd10, 4'd0, 13'd771},
      '{12'd384,  7'd25,  4'd1,  4'd2,  4'd0,  4'd1, 13'd682},
      '{12'd432,  7'd29,  4'd1,  4'd4,  4'd1,  4'd1, 13'd606},
      '{12'd460,  7'd29,  4'd6,  4'd5,  4'd0,  4'd0, 13'd569},
      '{12'd520,  7'd31,  4'd0,  4'd1,  4'd2,  4'd0, 13'd504},
      '{12'd576,  7'd31,  4'd0,  4'd0,  4'd0,  4'd0, 13'd455},
      '{12'd700,  7'd37,  4'd0,  4'd2,  4'd0,  4'd2, 13'd374},
      '{12'd776,  7'd39,  4'd7,  4'd0,  4'd0,  4'd0, 13'd337},
      '{12'd492,  7'd31,  4'd0,  4'd3,  4'd1,  4'd0, 13'd532},
      '{12'd752,  7'd37,  4'd1,  4'd3,  4'd4,  4'd2, 13'd348},
      '{12'd1056, 7'd43,  4'd0,  4'd0,  4'd6,  4'd2, 13'd248},
      '{12'd1192, 7'd49,  4'd0,  4'd3,  4'd5,  4'd0, 13'd219},
      '{12'd1332, 7'd49,  4'd0,  4'd5,  4'd0,  4'd5, 13'd196},
      '{12'd1420, 7'd53,  4'd1,  4'd4,  4'd6,  4'd2, 13'd184},
      '{12'd1600, 7'd53,  4'd1,  4'd10, 4'd7,  4'd1, 13'd163},
      '{12'd1776, 7'd59,  4'd3,  4'd8,  4'd5,  4'd1, 13'd147},
      '{12'd2156, 7'd65,  4'd0,  4'd3,  4'd7,  4'd0, 13'd121},
      '{12'd2396, 7'd81,  4'd1,  4'd2,  4'd5,  4'd2, 13'd109},
      '{12'd400,  7'd23,  4'd10, 4'd8,  4'd2,  4'd1, 13'd655},
      '{12'd680,  7'd33,  4'd9,  4'd15, 4'd3,  4'd1, 13'd385},
      '{12'd1752, 7'd59,  4'd1,  4'd1,  4'd2,  4'd1, 13'd149},
      '{12'd204,  7'd23,  4'd10, 4'd5,  4'd0,  4'd0, 13'd1285},
      '{12'd220,  7'd23,  4'd6,  4'd10, 4'd4,  4'd0, 13'd1191},
      '{12'd248,  7'd23,  4'd6,  4'd8,  4'd1,  4'd1, 13'd1057},
      '{12'd276,  7'd25,  4'd1,  4'd1,  4'd2,  4'd0, 13'd949},
      '{12'd336,  7'd23,  4'd8,  4'd1,  4'd4,  4'd1, 13'd780},
      '{12'd372,  7'd25,  4'd1,  4'd7,  4'd2,  4'd1, 13'd704},
      '{12'd64,   7'd19,  4'd1,  4'd3,  4'd8,  4'd1, 13'd4096},
      '{12'd228,  7'd23,  4'd1,  4'd11, 4'd2,  4'd3, 13'd1149},
      '{12'd440,  7'd49,  4'd1,  4'd9,  4'd8,  4'd1, 13'd595},
      '{12'd652,  7'd107, 4'd2,  4'd10, 4'd15, 4'd1, 13'd402},
      '{12'd864,  7'd67,  4'd2,  4'd4,  4'd13, 4'd5, 13'd303},
      '{12'd1504, 7'd53,  4'd2,  4'd1,  4'd2,  4'd2, 13'd174}
   };

   // table lookup result for one index
   typedef struct packed {
      logic                   hit;
      logic [ADDR_WIDTH-1:0]  n;
      logic [P_WIDTH-1:0]     p;
      logic [RECIP_WIDTH-1:0] recip;
      logic [OFS_WIDTH-1:0]   offset;
   } lookup_type;

   // beat handed to the modulo reduction pipe
   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [ADDR_WIDTH-1:0]   n;
      logic [RECIP_WIDTH-1:0]  recip;
      logic [SUM_WIDTH-1:0]    x;
   } red_beat_type;

endpackage

// ----- rtl/arp_interleaver_address.sv -----
// ARP interleaver address generator for turbo frames.
// Channels: req_* carries one index per beat, rsp_* one address and status per
// beat; both use valid/stall, a beat moves on a rising edge with valid high
// and stall low. csr_wr_en/csr_wr_data write the frame size register; write
// it only while no beats are in flight.
// Function: address = (p*i + Q(i mod 4) + 3) mod size, with p and Q from a
// built-in table of 36 sizes. Status 1 flags a size not in the table, status
// 2 an index not below the size; address is 0 for either.
// Stages: lookup, multiply-add, reciprocal multiply, remainder, correction +
// output register, from request beat to response beat.
// Throughput: one beat per cycle while not stalled; the pipe is five registers
// deep and the modulo is done by a reciprocal multiply, so no stage iterates.
// Stall: each stage holds while the next one is full and stalled; bubbles are
// squeezed out, so the input keeps taking beats until all five stages hold a
// beat. req_stall follows rsp_stall in the same cycle once the pipe is full.
// Reset: synchronous, clears all valid bits and sets the frame size to 56.
module arp_interleaver_address (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  arp_pkg::addr_type   csr_wr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  arp_pkg::addr_type   req_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output arp_pkg::addr_type   rsp_address,
   output arp_pkg::status_type rsp_status
);
   import arp_pkg::*;

   // frame size register
   addr_type      frame_size_ff;

   // stage 1: table lookup and range check
   lookup_type    look;
   logic          s1_valid_ff, s1_valid_in, s1_ready;
   lookup_type    s1_look_ff;
   addr_type      s1_index_ff;
   status_type    s1_status_ff, s1_status_in;

   // stage 2: x = p*i + offset + 3
   logic                   s2_valid_ff, s2_valid_in, s2_ready;
   red_beat_type           s2_beat_ff, s2_beat_in;
   logic [SUM_WIDTH:0]     s2_sum;

   logic                   red_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= FRAME_SIZE_RESET;
      end else if (csr_wr_en) begin
         frame_size_ff <= csr_wr_data;
      end
   end

   arp_lookup u_lookup (
      .frame_size (frame_size_ff),
      .phase      (req_index[1:0]),
      .look       (look)
   );

   // backpressure chain, bubbles collapse
   assign s2_ready  = !s2_valid_ff || !red_stall;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_stall = !s1_ready;

   assign s1_valid_in = s1_ready ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_comb begin
      if (!look.hit) begin
         s1_status_in = STATUS_BAD_SIZE;
      end else if (req_index >= frame_size_ff) begin
         s1_status_in = STATUS_BAD_INDEX;
      end else begin
         s1_status_in = STATUS_OK;
      end
   end

   // p*i < 2^19; the sum stays below 2^18 for every in-range index
   assign s2_sum = ({{ADDR_WIDTH{1'b0}}, s1_look_ff.p} * {{P_WIDTH{1'b0}}, s1_index_ff})
                 + {{(SUM_WIDTH+1-OFS_WIDTH){1'b0}}, s1_look_ff.offset}
                 + (SUM_WIDTH+1)'(3);

   always_comb begin
      s2_beat_in.status = s1_status_ff;
      s2_beat_in.n      = s1_look_ff.n;
      s2_beat_in.recip  = s1_look_ff.recip;
      s2_beat_in.x      = s2_sum[SUM_WIDTH-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_look_ff   <= look;
         s1_index_ff  <= req_index;
         s1_status_ff <= s1_status_in;
      end
      if (s2_ready) begin
         s2_beat_ff <= s2_beat_in;
      end
   end

   arp_modred u_modred (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid_ff),
      .in_stall    (red_stall),
      .in_beat     (s2_beat_ff),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_address (rsp_address),
      .out_status  (rsp_status)
   );

`ifndef SYNTHESIS
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && (s1_status_ff == STATUS_OK) |-> (s1_index_ff < s1_look_ff.n))
      else $error("index passed range check but is not below frame size");
`endif

endmodule

// ----- rtl/arp_lookup.sv -----
module arp_lookup (
   input  arp_pkg::addr_type   frame_size,
   input  logic [1:0]          phase,
   output arp_pkg::lookup_type look
);
   import arp_pkg::*;

   localparam logic [1:0] PHASE_ZERO = 2'd0;
   localparam logic [1:0] PHASE_ONE  = 2'd1;
   localparam logic [1:0] PHASE_TWO  = 2'd2;

   arp_entry_type                 ent;
   logic                          hit;
   logic [Q_WIDTH+P_WIDTH+1:0]    base;
   logic [Q_WIDTH+P_WIDTH+1:0]    ofs_wide;

   // sizes are unique, so at most one entry matches and an OR merge is exact
   always_comb begin
      ent = '0;
      hit = 1'b0;
      for (int k = 0; k < NUM_SIZES; k++) begin
         if (frame_size == ARP_TABLE[k].n) begin
            hit = 1'b1;
            ent = ent | ARP_TABLE[k];
         end
      end
   end

   // 4*q0*p
   assign base = {({{P_WIDTH{1'b0}}, ent.q0} * {{Q_WIDTH{1'b0}}, ent.p}), 2'b00};

   always_comb begin
      case (phase)
         PHASE_ZERO: ofs_wide = '0;
         PHASE_ONE:  ofs_wide = {{(P_WIDTH+2){1'b0}}, ent.q1} << 2;
         PHASE_TWO:  ofs_wide = base + ({{(P_WIDTH+2){1'b0}}, ent.q2} << 2);
         default:    ofs_wide = base + ({{(P_WIDTH+2){1'b0}}, ent.q3} << 2);
      endcase
   end

   assign look.hit    = hit;
   assign look.n      = ent.n;
   assign look.p      = ent.p;
   assign look.recip  = ent.recip;
   assign look.offset = ofs_wide[OFS_WIDTH-1:0];

endmodule

// ----- rtl/arp_modred.sv -----
module arp_modred (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  arp_pkg::red_beat_type in_beat,
   output logic                  out_valid,
   input  logic                  out_stall,
   output arp_pkg::addr_type     out_address,
   output arp_pkg::status_type   out_status
);
   import arp_pkg::*;

   // stage a: quotient estimate x*recip >> 18, off by at most one low
   logic                    a_valid_ff, a_valid_in, a_ready;
   logic [QUOT_WIDTH-1:0]   a_quot_ff, a_quot_in;
   red_beat_type            a_beat_ff;
   logic [PROD_WIDTH-1:0]   a_prod;

   // stage b: rem = x - quot*n, below 2n
   logic                    b_valid_ff, b_valid_in, b_ready;
   logic [REM_WIDTH-1:0]    b_rem_ff, b_rem_in;
   status_type              b_status_ff;
   addr_type                b_n_ff;
   logic [QUOT_WIDTH+ADDR_WIDTH-1:0] b_qn, b_diff;

   // stage c: final correction, output register
   logic                    c_valid_ff, c_valid_in, c_ready;
   addr_type                c_address_ff, c_address_in;
   status_type              c_status_ff;
   logic [REM_WIDTH-1:0]    c_fix;

   assign c_ready = !c_valid_ff || !out_stall;
   assign b_ready = !b_valid_ff || c_ready;
   assign a_ready = !a_valid_ff || b_ready;
   assign in_stall = !a_ready;

   assign a_valid_in = a_ready ? in_valid   : a_valid_ff;
   assign b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
   assign c_valid_in = c_ready ? b_valid_ff : c_valid_ff;

   assign a_prod    = {{RECIP_WIDTH{1'b0}}, in_beat.x} * {{SUM_WIDTH{1'b0}}, in_beat.recip};
   assign a_quot_in = a_prod[PROD_WIDTH-1:RECIP_SHIFT];

   assign b_qn     = {{ADDR_WIDTH{1'b0}}, a_quot_ff} * {{QUOT_WIDTH{1'b0}}, a_beat_ff.n};
   assign b_diff   = {{(QUOT_WIDTH+ADDR_WIDTH-SUM_WIDTH){1'b0}}, a_beat_ff.x} - b_qn;
   assign b_rem_in = b_diff[REM_WIDTH-1:0];

   always_comb begin
      c_fix = b_rem_ff;
      if (b_rem_ff >= {1'b0, b_n_ff}) begin
         c_fix = b_rem_ff - {1'b0, b_n_ff};
      end
      c_address_in = (b_status_ff == STATUS_OK) ? c_fix[ADDR_WIDTH-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_quot_ff <= a_quot_in;
         a_beat_ff <= in_beat;
      end
      if (b_ready) begin
         b_rem_ff    <= b_rem_in;
         b_status_ff <= a_beat_ff.status;
         b_n_ff      <= a_beat_ff.n;
      end
      if (c_ready) begin
         c_address_ff <= c_address_in;
         c_status_ff  <= b_status_ff;
      end
   end

   assign out_valid   = c_valid_ff;
   assign out_address = c_address_ff;
   assign out_status  = c_status_ff;

`ifndef SYNTHESIS
   // one correction step must be enough
   assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && (b_status_ff == STATUS_OK) |-> (b_rem_ff < {b_n_ff, 1'b0}))
      else $error("modulo estimate off by more than one");

   assert property (@(posedge clock) disable iff (reset)
      c_valid_ff && (c_status_ff != STATUS_OK) |-> (c_address_ff == '0))
      else $error("nonzero address on error status");
`endif

endmodule
